// ----- hdl/arpc_pkg.sv -----
`timescale 1ns / 1ps

package arpc_pkg;

   localparam int TABLE_ENTRIES = 8;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(TABLE_ENTRIES - 1);

   localparam int PROTO_W     = 32;
   localparam int HW_W        = 48;
   localparam int OPCODE_W    = 16;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 48;

   localparam logic [OPCODE_W-1:0] OPCODE_REPLY = 16'd2;

   // operation codes
   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_REPLY  = 1'b1;

   // update status codes
   localparam logic [1:0] UPD_NONE    = 2'd0;
   localparam logic [1:0] UPD_REFRESH = 2'd1;
   localparam logic [1:0] UPD_INSERT  = 2'd2;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_PROTO = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_HW    = 8'd1;

   typedef struct packed {
      logic                operation;
      logic [PROTO_W-1:0]  query_address;
      logic [HW_W-1:0]     sender_hw_address;
      logic [PROTO_W-1:0]  target_proto_address;
      logic [HW_W-1:0]     target_hw_address;
      logic [OPCODE_W-1:0] packet_opcode;
   } req_type;

   typedef struct packed {
      logic            hit;
      logic [HW_W-1:0] found_hw_address;
      logic [1:0]      update_status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   typedef struct packed {
      logic load;    // capture request, restart scan
      logic step;    // advance scan index
      logic record;  // remember current index as the match
      logic commit;  // update table, load response register
   } cmd_type;

   typedef struct packed {
      logic match;     // entry at scan index holds the query address
      logic last;      // scan index is at the final entry
      logic out_free;  // response register can take a new response
   } status_type;

endpackage

// ----- hdl/arpc_ctrl.sv -----
`timescale 1ns / 1ps

module arpc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  arpc_pkg::status_type status,
   output arpc_pkg::cmd_type    cmd,
   output logic                 idle
);

   arpc_pkg::state_type state_ff;
   arpc_pkg::state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      idle       = 1'b0;
      case (state_ff)
         arpc_pkg::ST_IDLE: begin
            idle = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = arpc_pkg::ST_SCAN;
            end
         end
         arpc_pkg::ST_SCAN: begin
            if (status.match) begin
               cmd.record = 1'b1;
               state_in   = arpc_pkg::ST_FINISH;
            end else if (status.last) begin
               state_in = arpc_pkg::ST_FINISH;
            end else begin
               cmd.step = 1'b1;
            end
         end
         arpc_pkg::ST_FINISH: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = arpc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = arpc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= arpc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // a request is only taken with no lookup or update in flight
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !cmd.commit && !idle)
      else $error("request taken while busy");

endmodule

// ----- hdl/arpc_datapath.sv -----
`timescale 1ns / 1ps

module arpc_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  arpc_pkg::req_type                     req_data,
   output arpc_pkg::rsp_type                     rsp_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic                                  csr_write,
   input  logic [arpc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [arpc_pkg::CSR_DATA_W-1:0]       csr_data,
   input  arpc_pkg::cmd_type                     cmd,
   output arpc_pkg::status_type                  status
);

   // configuration
   logic [arpc_pkg::PROTO_W-1:0] own_proto_ff;
   logic [arpc_pkg::HW_W-1:0]    own_hw_ff;

   // table
   logic [arpc_pkg::PROTO_W-1:0] proto_table_ff [arpc_pkg::TABLE_ENTRIES];
   logic [arpc_pkg::HW_W-1:0]    hw_table_ff    [arpc_pkg::TABLE_ENTRIES];
   logic [arpc_pkg::IDX_W-1:0]   next_slot_ff;
   logic [arpc_pkg::IDX_W-1:0]   next_slot_in;

   // working registers
   arpc_pkg::req_type            req_ff;
   logic [arpc_pkg::IDX_W-1:0]   scan_idx_ff;
   logic [arpc_pkg::IDX_W-1:0]   match_idx_ff;
   logic                         hit_ff;

   // response register
   arpc_pkg::rsp_type            rsp_ff;
   arpc_pkg::rsp_type            rsp_in;
   logic                         rsp_valid_ff;

   logic                         reply_ok;
   logic [arpc_pkg::IDX_W-1:0]   write_idx;

   assign status.match    = (proto_table_ff[scan_idx_ff] == req_ff.query_address);
   assign status.last     = (scan_idx_ff == arpc_pkg::LAST_INDEX);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign reply_ok = (req_ff.operation == arpc_pkg::OP_REPLY) &&
                     (req_ff.packet_opcode == arpc_pkg::OPCODE_REPLY) &&
                     (req_ff.target_proto_address == own_proto_ff) &&
                     (req_ff.target_hw_address == own_hw_ff);

   assign write_idx    = hit_ff ? match_idx_ff : next_slot_ff;
   assign next_slot_in = (next_slot_ff == arpc_pkg::LAST_INDEX) ? '0
                                                               : next_slot_ff + 1'b1;

   always_comb begin
      rsp_in = '0;
      if (req_ff.operation == arpc_pkg::OP_LOOKUP) begin
         rsp_in.hit = hit_ff;
         if (hit_ff) begin
            rsp_in.found_hw_address = hw_table_ff[match_idx_ff];
         end
      end else if (reply_ok) begin
         rsp_in.update_status = hit_ff ? arpc_pkg::UPD_REFRESH : arpc_pkg::UPD_INSERT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_proto_ff <= '0;
         own_hw_ff    <= '0;
      end else if (csr_write) begin
         if (csr_index == arpc_pkg::CSR_OWN_PROTO) begin
            own_proto_ff <= csr_data[arpc_pkg::PROTO_W-1:0];
         end else if (csr_index == arpc_pkg::CSR_OWN_HW) begin
            own_hw_ff <= csr_data[arpc_pkg::HW_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < arpc_pkg::TABLE_ENTRIES; i++) begin
            proto_table_ff[i] <= '0;
            hw_table_ff[i]    <= '0;
         end
         next_slot_ff <= '0;
      end else if (cmd.commit && reply_ok) begin
         hw_table_ff[write_idx] <= req_ff.sender_hw_address;
         if (!hit_ff) begin
            proto_table_ff[write_idx] <= req_ff.query_address;
            next_slot_ff              <= next_slot_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.record) begin
         match_idx_ff <= scan_idx_ff;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff  <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            scan_idx_ff <= '0;
            hit_ff      <= 1'b0;
         end else if (cmd.step) begin
            scan_idx_ff <= scan_idx_ff + 1'b1;
         end
         if (cmd.record) begin
            hit_ff <= 1'b1;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   // a response is never overwritten while it still waits
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid_ff && rsp_stall))
      else $error("pending response overwritten");

   // lookups never report a table change
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit && req_ff.operation == arpc_pkg::OP_LOOKUP
      |=> rsp_ff.update_status == arpc_pkg::UPD_NONE)
      else $error("lookup reported an update");

   // replies never report a hit
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit && req_ff.operation == arpc_pkg::OP_REPLY
      |=> !rsp_ff.hit && rsp_ff.found_hw_address == '0)
      else $error("reply reported a hit");

   // an insert moves the round-robin pointer, a refresh leaves it
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit && reply_ok && hit_ff |=> $stable(next_slot_ff))
      else $error("refresh moved the replacement pointer");

endmodule

// ----- hdl/arp_cache_round_robin.sv -----
// Address-resolution cache: eight entries mapping 32-bit protocol addresses to
// 48-bit hardware addresses. A lookup request (operation 0) returns hit and the
// hardware address of the lowest-numbered matching entry. A reply request
// (operation 1) updates the table only when its opcode is 2 and its target
// protocol and hardware addresses equal the own addresses in CSR 0 and CSR 1;
// a known sender is refreshed in place, an unknown one is written at the
// round-robin slot. Every request gives exactly one response. The table resets
// to all zeros, so a lookup of address 0 hits an unused entry. Steps: take the
// request, scan the entries one at a time with the single compare unit
// (stopping at the first match), then update the table and load the response
// register once that register is free.
// Requests are handled one at a time; a new request is taken while the
// previous response still waits in the output register. CSR writes are
// always ready and must only be issued while no request is in flight.
`timescale 1ns / 1ps

module arp_cache_round_robin (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  arpc_pkg::req_type                  req_data,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output arpc_pkg::rsp_type                  rsp_data,
   // CSR write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [arpc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [arpc_pkg::CSR_DATA_W-1:0]    csr_data
);

   arpc_pkg::cmd_type    cmd;
   arpc_pkg::status_type status;
   logic                 idle;

   // request taken only from idle; scan and update own the table otherwise
   assign req_stall = !idle;
   assign csr_ready = 1'b1;

   arpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd),
      .idle      (idle)
   );

   arpc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

   // write to an index that decodes to no register; must be ignored
   localparam logic [arpc_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 8'hFF;
   localparam int POOL_SIZE   = 12;
   localparam int LONG_STALL  = 300;  // cycles the receiver holds off once
   localparam int LONG_AT     = 600;  // response count that triggers it

   typedef struct packed {
      logic [arpc_pkg::CSR_INDEX_W-1:0] index;
      logic [arpc_pkg::CSR_DATA_W-1:0]  data;
   } csr_write_type;

   // DUT ports; the inputs driven here are all known from time zero
   logic clock     = 1'b0;
   logic reset     = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   arpc_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   arpc_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [arpc_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [arpc_pkg::CSR_DATA_W-1:0]  csr_data  = '0;

   // stimulus and expectation stores
   arpc_pkg::req_type request_fifo[$];
   arpc_pkg::rsp_type response_fifo[$];
   csr_write_type     csr_fifo[$];

   // shadow of the cache state and own-address registers
   logic [arpc_pkg::PROTO_W-1:0] shadow_proto[arpc_pkg::TABLE_ENTRIES] = '{default: '0};
   logic [arpc_pkg::HW_W-1:0]    shadow_hw[arpc_pkg::TABLE_ENTRIES]    = '{default: '0};
   logic [arpc_pkg::IDX_W-1:0]   shadow_next  = '0;
   logic [arpc_pkg::PROTO_W-1:0] own_proto_q  = '0;
   logic [arpc_pkg::HW_W-1:0]    own_hw_q     = '0;

   logic [arpc_pkg::PROTO_W-1:0] addr_pool[POOL_SIZE];
   bit quiet = 1'b0;  // no idling on either side in the last phase

   int errors = 0;
   int n_hit = 0, n_miss = 0, n_refresh = 0, n_insert = 0, n_reject = 0;
   int n_resp = 0, n_settings = 1;

   arp_cache_round_robin u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("arp_cache_round_robin test failed");
      $finish;
   end

   task automatic report_mismatch(input string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // Expected response of one request; updates the shadow table.
   function automatic arpc_pkg::rsp_type resolve_request(input arpc_pkg::req_type r);
      arpc_pkg::rsp_type res;
      int slot;
      int i;
      res  = '0;
      slot = -1;
      // first matching entry wins, so scan downward and keep the last hit
      for (i = arpc_pkg::TABLE_ENTRIES - 1; i >= 0; i--)
         if (shadow_proto[i] == r.query_address) slot = i;
      if (r.operation == arpc_pkg::OP_LOOKUP) begin
         if (slot >= 0) begin
            res.hit = 1'b1;
            res.found_hw_address = shadow_hw[slot];
            n_hit++;
         end else begin
            n_miss++;
         end
      end else if (r.packet_opcode == arpc_pkg::OPCODE_REPLY
                   && r.target_proto_address == own_proto_q
                   && r.target_hw_address == own_hw_q) begin
         if (slot >= 0) begin
            shadow_hw[slot] = r.sender_hw_address;
            res.update_status = arpc_pkg::UPD_REFRESH;
            n_refresh++;
         end else begin
            shadow_proto[shadow_next] = r.query_address;
            shadow_hw[shadow_next]    = r.sender_hw_address;
            shadow_next = (shadow_next == arpc_pkg::LAST_INDEX) ? '0 : shadow_next + 1'b1;
            res.update_status = arpc_pkg::UPD_INSERT;
            n_insert++;
         end
      end else begin
         res.update_status = arpc_pkg::UPD_NONE;
         n_reject++;
      end
      return res;
   endfunction

   // Request driver: holds a stalled request, otherwise inserts random gaps.
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid)
            response_fifo.push_back(resolve_request(req_data));
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            send_gap = $urandom_range(0, 11);
            req_valid <= 1'b0;
         end else if (request_fifo.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= request_fifo.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // One long receiver hold-off lets the block fill up and push back on requests.
   bit long_hold = 1'b0;
   initial begin
      wait (n_resp >= LONG_AT);
      long_hold = 1'b1;
      repeat (LONG_STALL) @(posedge clock);
      long_hold = 1'b0;
   end

   // Response monitor: checks, then picks the stall for the next cycle.
   int  stall_gap = 0;
   always @(posedge clock) begin
      arpc_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            n_resp++;
            if (response_fifo.size() == 0) begin
               report_mismatch("response with nothing expected");
            end else begin
               want = response_fifo.pop_front();
               if (rsp_data.hit !== want.hit)
                  report_mismatch($sformatf("hit got %0b want %0b",
                                            rsp_data.hit, want.hit));
               if (rsp_data.found_hw_address !== want.found_hw_address)
                  report_mismatch($sformatf("found_hw_address got %h want %h",
                                            rsp_data.found_hw_address,
                                            want.found_hw_address));
               if (rsp_data.update_status !== want.update_status)
                  report_mismatch($sformatf("update_status got %0d want %0d",
                                            rsp_data.update_status, want.update_status));
            end
         end
         if (long_hold) begin
            rsp_stall <= 1'b1;
         end else if (stall_gap > 0) begin
            stall_gap--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            stall_gap = $urandom_range(0, 11);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Register write channel; the shadow registers follow accepted writes.
   always @(posedge clock) begin
      csr_write_type w;
      if (reset) begin
         csr_valid <= 1'b0;
      end else if (!(csr_valid && !csr_ready)) begin
         if (csr_valid) begin
            if (csr_index == arpc_pkg::CSR_OWN_PROTO)
               own_proto_q = csr_data[arpc_pkg::PROTO_W-1:0];
            else if (csr_index == arpc_pkg::CSR_OWN_HW)
               own_hw_q = csr_data[arpc_pkg::HW_W-1:0];
         end
         if (csr_fifo.size() > 0) begin
            w = csr_fifo.pop_front();
            csr_valid <= 1'b1;
            csr_index <= w.index;
            csr_data  <= w.data;
         end else begin
            csr_valid <= 1'b0;
         end
      end
   end

   function automatic logic [arpc_pkg::HW_W-1:0] random_hw();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[arpc_pkg::HW_W-1:0];
   endfunction

   function automatic arpc_pkg::req_type make_req(
         input logic                          op,
         input logic [arpc_pkg::PROTO_W-1:0]  qa,
         input logic [arpc_pkg::HW_W-1:0]     sha,
         input logic [arpc_pkg::PROTO_W-1:0]  tpa,
         input logic [arpc_pkg::HW_W-1:0]     tha,
         input logic [arpc_pkg::OPCODE_W-1:0] opc);
      arpc_pkg::req_type r;
      r.operation            = op;
      r.query_address        = qa;
      r.sender_hw_address    = sha;
      r.target_proto_address = tpa;
      r.target_hw_address    = tha;
      r.packet_opcode        = opc;
      return r;
   endfunction

   // Mostly well-formed replies and lookups over a small address pool so that
   // refreshes, hits and evictions are frequent; the rest is rejected noise.
   function automatic arpc_pkg::req_type random_request();
      arpc_pkg::req_type r;
      logic [arpc_pkg::PROTO_W-1:0] qa;
      int pick;
      qa = ($urandom_range(0, 7) == 0) ? $urandom
                                       : addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      pick = $urandom_range(0, 99);
      r = make_req(arpc_pkg::OP_REPLY, qa, random_hw(), own_proto_q, own_hw_q,
                   arpc_pkg::OPCODE_REPLY);
      if (pick < 45) begin
         // lookup with garbage in the reply-only fields
         r = make_req(arpc_pkg::OP_LOOKUP, qa, random_hw(), $urandom, random_hw(),
                      arpc_pkg::OPCODE_W'($urandom));
      end else if (pick < 85) begin
         // well-formed reply, already set up above
      end else if (pick < 89) begin
         r.packet_opcode = arpc_pkg::OPCODE_W'($urandom);
      end else if (pick < 93) begin
         r.target_proto_address ^= arpc_pkg::PROTO_W'(1)
                                   << $urandom_range(0, arpc_pkg::PROTO_W - 1);
      end else if (pick < 97) begin
         r.target_hw_address ^= arpc_pkg::HW_W'(1)
                                << $urandom_range(0, arpc_pkg::HW_W - 1);
      end else begin
         r.target_proto_address = $urandom;
         r.target_hw_address    = random_hw();
      end
      return r;
   endfunction

   // Wait until every request is answered and the block is idle again.
   task automatic drain();
      while (request_fifo.size() != 0 || req_valid || response_fifo.size() != 0
             || csr_fifo.size() != 0 || csr_valid)
         @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   // Program own addresses while idle and pick a fresh address pool.
   task automatic apply_setting(input logic [arpc_pkg::PROTO_W-1:0] proto,
                                input logic [arpc_pkg::HW_W-1:0] hw);
      int i;
      drain();
      csr_fifo.push_back('{index: arpc_pkg::CSR_OWN_PROTO,
                           data: arpc_pkg::CSR_DATA_W'(proto)});
      csr_fifo.push_back('{index: arpc_pkg::CSR_OWN_HW,
                           data: arpc_pkg::CSR_DATA_W'(hw)});
      drain();
      n_settings++;
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (i = 2; i < POOL_SIZE; i++) addr_pool[i] = $urandom;
   endtask

   task automatic random_phase(input int count);
      int i;
      for (i = 0; i < count; i++) request_fifo.push_back(random_request());
   endtask

   initial begin
      int i;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, own addresses at their reset value of zero.
      // Unused entries hold address zero, so a lookup of zero hits.
      request_fifo.push_back(make_req(arpc_pkg::OP_LOOKUP, '0, '0, '0, '0, '0));
      request_fifo.push_back(make_req(arpc_pkg::OP_LOOKUP, '1, '1, '1, '1, '1));
      // rejected replies: wrong opcode, wrong target protocol, wrong target hw
      request_fifo.push_back(make_req(arpc_pkg::OP_REPLY, 32'h0A00_0001, 48'h1, '0, '0,
                                      16'd1));
      request_fifo.push_back(make_req(arpc_pkg::OP_REPLY, 32'h0A00_0001, '1, '0, '0, '1));
      request_fifo.push_back(make_req(arpc_pkg::OP_REPLY, 32'h0A00_0001, 48'h2, 32'h1, '0,
                                      arpc_pkg::OPCODE_REPLY));
      request_fifo.push_back(make_req(arpc_pkg::OP_REPLY, 32'h0A00_0001, 48'h3, '0,
                                      48'h8000_0000_0000, arpc_pkg::OPCODE_REPLY));
      // insert, then refresh the same sender
      request_fifo.push_back(make_req(arpc_pkg::OP_REPLY, 32'h0A00_0001, 48'h0000_1111_2222,
                                      '0, '0, arpc_pkg::OPCODE_REPLY));
      request_fifo.push_back(make_req(arpc_pkg::OP_REPLY, 32'h0A00_0001, '1, '0, '0,
                                      arpc_pkg::OPCODE_REPLY));
      request_fifo.push_back(make_req(arpc_pkg::OP_LOOKUP, 32'h0A00_0001, '0, '0, '0, '0));
      // sender zero refreshes an unused entry in place
      request_fifo.push_back(make_req(arpc_pkg::OP_REPLY, '0, 48'h123, '0, '0,
                                      arpc_pkg::OPCODE_REPLY));
      request_fifo.push_back(make_req(arpc_pkg::OP_LOOKUP, '0, '0, '0, '0, '0));
      // fill past the table size so the slot pointer wraps and evicts
      for (i = 0; i < 9; i++)
         request_fifo.push_back(make_req(arpc_pkg::OP_REPLY, 32'hC0A8_0000 + i, random_hw(),
                                         '0, '0, arpc_pkg::OPCODE_REPLY));
      request_fifo.push_back(make_req(arpc_pkg::OP_LOOKUP, 32'h0A00_0001, '0, '0, '0, '0));
      request_fifo.push_back(make_req(arpc_pkg::OP_LOOKUP, 32'hC0A8_0008, '0, '0, '0, '0));
      drain();

      // all-ones own addresses
      apply_setting('1, '1);
      request_fifo.push_back(make_req(arpc_pkg::OP_REPLY, '1, '0, '1, '1,
                                      arpc_pkg::OPCODE_REPLY));
      request_fifo.push_back(make_req(arpc_pkg::OP_LOOKUP, '1, '0, '0, '0, '0));
      request_fifo.push_back(make_req(arpc_pkg::OP_REPLY, 32'h5, 48'h5, '0, '0,
                                      arpc_pkg::OPCODE_REPLY));
      random_phase(300);

      apply_setting($urandom, random_hw());
      random_phase(400);   // long receiver hold-off lands here

      // back to zero, plus a write to an index that maps to nothing
      apply_setting('0, '0);
      csr_fifo.push_back('{index: CSR_UNUSED, data: arpc_pkg::CSR_DATA_W'(random_hw())});
      drain();
      random_phase(400);

      apply_setting($urandom, random_hw());
      random_phase(400);

      // last stretch runs with no idling on either side
      apply_setting($urandom, random_hw());
      quiet = 1'b1;
      random_phase(430);
      drain();

      repeat (20) @(posedge clock);
      if (response_fifo.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", response_fifo.size()));
      $display("covered %0d responses over %0d own-address settings", n_resp, n_settings);
      $display("lookups %0d hit / %0d miss, replies %0d refresh / %0d insert / %0d rejected",
               n_hit, n_miss, n_refresh, n_insert, n_reject);
      if (errors == 0)
         $display("arp_cache_round_robin test passed");
      else
         $display("arp_cache_round_robin test failed");
      $finish;
   end

endmodule
